@@ hdl/lupp_pkg.sv @@
// Shared types and constants of the LU decomposition block.
package lupp_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam logic [4:0] DIM_RESET = 5'd16;

    localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] Q_ZERO = 32'sh0000_0000;
    localparam logic signed [31:0] Q_MAX  = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SINGULAR = 2'd1,
        ST_PENDING  = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RESP,
        OP_RD_ENTRY,
        OP_RESP_RD,
        OP_INIT,
        OP_PIV_CLR,
        OP_PIV_RD,
        OP_PRD,
        OP_PSAVE_RD,
        OP_PWR_NEW,
        OP_PWR_OLD,
        OP_RS_RD,
        OP_RS_WA,
        OP_RS_WB,
        OP_PIVK_RD,
        OP_PIVK_CAP,
        OP_D_RD,
        OP_D_START,
        OP_D_WR,
        OP_E_RD,
        OP_E_MUL,
        OP_E_SHF,
        OP_E_WR
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    in_range;
        logic    upper;
        logic    diag;
        logic    pmark;
        logic    lsw;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic found;
        logic div_busy;
        logic out_full;
    } dp_stat_t;

endpackage

@@ hdl/lupp_if.sv @@
// Request and response channel interfaces.
interface lupp_req_if
    import lupp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;

    modport source (output valid, command, row, col, value, input ready);
    modport sink (input valid, command, row, col, value, output ready);
endinterface

interface lupp_rsp_if
    import lupp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] lower_value;
    logic signed [31:0] upper_value;
    logic [3:0]         perm_index;

    modport source (output valid, status, lower_value, upper_value, perm_index, input ready);
    modport sink (input valid, status, lower_value, upper_value, perm_index, output ready);
endinterface

@@ hdl/lupp_div.sv @@
// Restoring divider for the Q16.16 quotient, one bit per cycle, saturating.
module lupp_div
    import lupp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               busy,
    output logic signed [31:0] quo
);
    localparam int STEPS = 48;
    localparam int CW = $clog2(STEPS);

    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [47:0]   q_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   d_reg;
    logic          neg_reg;
    logic [32:0]   rem_sh;
    logic [32:0]   rem_sub;
    logic [32:0]   num_x;
    logic [32:0]   den_x;
    logic [31:0]   num_mag;
    logic [31:0]   den_mag;

    assign num_x   = {num[31], num};
    assign den_x   = {den[31], den};
    assign num_mag = num[31] ? 32'(-num_x) : num_x[31:0];
    assign den_mag = den[31] ? 32'(-den_x) : den_x[31:0];
    assign rem_sh  = {rem_reg, q_reg[47]};
    assign rem_sub = rem_sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(STEPS - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= {num_mag, 16'h0000};
            rem_reg <= '0;
            d_reg   <= den_mag;
            neg_reg <= num[31] ^ den[31];
        end
        else if (busy_reg)
        begin
            if (!rem_sub[32])
            begin
                rem_reg <= rem_sub[31:0];
                q_reg   <= {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[31:0];
                q_reg   <= {q_reg[46:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (q_reg > 48'h0000_8000_0000)
            begin
                quo = Q_MIN;
            end
            else
            begin
                quo = 32'(-q_reg);
            end
        end
        else if (q_reg > 48'h0000_7fff_ffff)
        begin
            quo = Q_MAX;
        end
        else
        begin
            quo = q_reg[31:0];
        end
    end

    assign busy = busy_reg;

endmodule

@@ hdl/lupp_dp.sv @@
// Datapath: matrix memories, pivot search, divider, multiply and response register.
module lupp_dp
    import lupp_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  dp_cmd_t                          cmd,
    input  logic [2*$clog2(MAX_DIM)-1:0]     wa,
    input  logic [2*$clog2(MAX_DIM)-1:0]     wb,
    input  logic [2*$clog2(MAX_DIM)-1:0]     la,
    input  logic [2*$clog2(MAX_DIM)-1:0]     lb,
    input  logic [2*$clog2(MAX_DIM)-1:0]     ua,
    input  logic [$clog2(MAX_DIM)-1:0]       pa,
    input  logic signed [31:0]               value,
    output logic [$clog2(MAX_DIM)-1:0]       kd,
    output dp_stat_t                         stat,
    lupp_rsp_if.source                       rsp
);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int PDEPTH = 1 << IDX_W;

    logic signed [31:0] w_mem [DEPTH];
    logic signed [31:0] l_mem [DEPTH];
    logic signed [31:0] u_mem [DEPTH];
    logic [IDX_W-1:0]   p_mem [PDEPTH];

    logic signed [31:0] w_rda, w_rdb, l_rda, l_rdb, u_rda;
    logic [IDX_W-1:0]   pr_reg, tmp_reg;

    dp_op_t             op_d_reg;
    logic [ADDR_W-1:0]  wa_d_reg;
    logic               inside_d_reg, upper_d_reg, diag_d_reg;

    logic signed [31:0] best_reg;
    logic [IDX_W-1:0]   kd_reg;
    logic               found_reg;
    logic signed [31:0] piv_reg;
    logic signed [63:0] prod_reg;
    logic signed [47:0] qs_reg;
    logic               perm_init_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic signed [31:0] out_lower_reg, out_upper_reg;
    logic [3:0]         out_perm_reg;

    logic               w_we, l_we, u_we, w_re, l_re, u_re, p_re, p_we, push;
    logic [ADDR_W-1:0]  l_wa, u_wa;
    logic signed [31:0] w_wd, l_wd, u_wd;
    logic [IDX_W-1:0]   p_wd;
    logic signed [31:0] div_q, mag, e_p, e_res;
    logic signed [32:0] e_diff;
    logic signed [63:0] prod_c;
    logic               div_busy;

    function automatic logic signed [31:0] sat_q(input logic signed [47:0] v);
        if (v > 48'sh0000_7fff_ffff)
        begin
            return Q_MAX;
        end
        else if (v < -48'sh0000_8000_0000)
        begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    lupp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_D_START),
        .num   (w_rda),
        .den   (piv_reg),
        .busy  (div_busy),
        .quo   (div_q)
    );

    assign mag    = (w_rda == Q_MIN) ? Q_MAX : (w_rda[31] ? -w_rda : w_rda);
    assign prod_c = prod_reg[63] ? prod_reg + 64'sd65535 : prod_reg;
    assign e_p    = sat_q(qs_reg);
    assign e_diff = {w_rda[31], w_rda} - {e_p[31], e_p};
    assign e_res  = (e_diff[32] != e_diff[31]) ? (e_diff[32] ? Q_MIN : Q_MAX) : e_diff[31:0];

    always_comb
    begin
        w_we = 1'b0;
        w_wd = w_rda;
        l_we = 1'b0;
        l_wa = la;
        l_wd = l_rda;
        u_we = 1'b0;
        u_wa = ua;
        u_wd = w_rdb;
        p_we = 1'b0;
        p_wd = pa;
        case (cmd.op)
            OP_LOAD:
            begin
                w_we = cmd.in_range;
                w_wd = value;
            end
            OP_INIT:
            begin
                p_we = cmd.pmark;
            end
            OP_PWR_NEW:
            begin
                p_we = 1'b1;
                p_wd = pr_reg;
            end
            OP_PWR_OLD:
            begin
                p_we = 1'b1;
                p_wd = tmp_reg;
            end
            OP_RS_WA:
            begin
                w_we = 1'b1;
                w_wd = w_rdb;
                l_we = cmd.lsw;
                l_wd = l_rdb;
            end
            OP_RS_WB:
            begin
                w_we = 1'b1;
                l_we = cmd.lsw;
            end
            OP_D_START:
            begin
                u_we = 1'b1;
            end
            OP_D_WR:
            begin
                l_we = 1'b1;
                l_wd = div_q;
            end
            OP_E_WR:
            begin
                w_we = 1'b1;
                w_wd = e_res;
            end
            default:
            begin
                w_we = 1'b0;
            end
        endcase
        if (op_d_reg == OP_INIT)
        begin
            l_we = 1'b1;
            l_wa = wa_d_reg;
            u_we = 1'b1;
            u_wa = wa_d_reg;
            l_wd = Q_ZERO;
            u_wd = Q_ZERO;
            if (inside_d_reg)
            begin
                if (diag_d_reg)
                begin
                    l_wd = Q_ONE;
                    u_wd = w_rda;
                end
                else if (upper_d_reg)
                begin
                    u_wd = w_rda;
                end
                else
                begin
                    l_wd = w_rda;
                end
            end
        end
    end

    assign w_re = cmd.op inside {OP_INIT, OP_PIV_RD, OP_RS_RD, OP_PIVK_RD, OP_D_RD, OP_E_RD};
    assign l_re = cmd.op inside {OP_RD_ENTRY, OP_RS_RD, OP_E_RD};
    assign u_re = cmd.op inside {OP_RD_ENTRY, OP_E_RD};
    assign p_re = cmd.op inside {OP_RD_ENTRY, OP_PRD, OP_PSAVE_RD};
    assign push = cmd.op inside {OP_LOAD, OP_RESP, OP_RESP_RD};

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[wa] <= w_wd;
        end
        if (w_re)
        begin
            w_rda <= w_mem[wa];
            w_rdb <= w_mem[wb];
        end
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            l_mem[l_wa] <= l_wd;
        end
        if (l_re)
        begin
            l_rda <= l_mem[la];
            l_rdb <= l_mem[lb];
        end
    end

    always_ff @(posedge clk)
    begin
        if (u_we)
        begin
            u_mem[u_wa] <= u_wd;
        end
        if (u_re)
        begin
            u_rda <= u_mem[ua];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            p_mem[pa] <= p_wd;
        end
        if (p_re)
        begin
            pr_reg <= p_mem[pa];
        end
        if (cmd.op == OP_PSAVE_RD)
        begin
            tmp_reg <= pr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wa_d_reg     <= wa;
        inside_d_reg <= cmd.in_range;
        upper_d_reg  <= cmd.upper;
        diag_d_reg   <= cmd.diag;
        if (cmd.op == OP_PIVK_CAP)
        begin
            piv_reg <= w_rda;
        end
        if (cmd.op == OP_E_MUL)
        begin
            prod_reg <= l_rda * u_rda;
        end
        if (cmd.op == OP_E_SHF)
        begin
            qs_reg <= 48'(prod_c >>> 16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_d_reg      <= OP_NONE;
            found_reg     <= 1'b0;
            best_reg      <= Q_ZERO;
            kd_reg        <= '0;
            perm_init_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            op_d_reg <= cmd.op;
            if (cmd.op == OP_INIT)
            begin
                perm_init_reg <= 1'b1;
            end
            if (cmd.op == OP_PIV_CLR)
            begin
                found_reg <= 1'b0;
                best_reg  <= Q_ZERO;
            end
            else if (op_d_reg == OP_PIV_RD && best_reg < mag)
            begin
                found_reg <= 1'b1;
                best_reg  <= mag;
                kd_reg    <= wa_d_reg[ADDR_W-1:IDX_W];
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_status_reg <= cmd.status;
            out_lower_reg  <= Q_ZERO;
            out_upper_reg  <= Q_ZERO;
            out_perm_reg   <= '0;
            if (cmd.op == OP_RESP_RD)
            begin
                if (cmd.in_range)
                begin
                    out_lower_reg <= l_rda;
                    out_upper_reg <= u_rda;
                end
                if (cmd.upper)
                begin
                    out_perm_reg <= perm_init_reg ? 4'(pr_reg) : 4'(pa);
                end
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.lower_value = out_lower_reg;
    assign rsp.upper_value = out_upper_reg;
    assign rsp.perm_index  = out_perm_reg;

    assign kd            = kd_reg;
    assign stat.found    = found_reg;
    assign stat.div_busy = div_busy;
    assign stat.out_full = out_valid_reg;

endmodule

@@ hdl/lupp_ctrl.sv @@
// Controller: command decode, dimension register and factorisation sequencer.
module lupp_ctrl
    import lupp_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    lupp_req_if.sink                      req,
    input  logic                          cfg_wr_en,
    input  logic [4:0]                    cfg_wr_data,
    output dp_cmd_t                       cmd,
    output logic [2*$clog2(MAX_DIM)-1:0]  wa,
    output logic [2*$clog2(MAX_DIM)-1:0]  wb,
    output logic [2*$clog2(MAX_DIM)-1:0]  la,
    output logic [2*$clog2(MAX_DIM)-1:0]  lb,
    output logic [2*$clog2(MAX_DIM)-1:0]  ua,
    output logic [$clog2(MAX_DIM)-1:0]    pa,
    input  logic [$clog2(MAX_DIM)-1:0]    kd,
    input  dp_stat_t                      stat
);
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_DIM - 1);

    typedef enum logic [23:0] {
        S_IDLE   = 24'h000001,
        S_READ   = 24'h000002,
        S_INIT   = 24'h000004,
        S_KTOP   = 24'h000008,
        S_PIV    = 24'h000010,
        S_PIVW   = 24'h000020,
        S_PIVCHK = 24'h000040,
        S_PS0    = 24'h000080,
        S_PS1    = 24'h000100,
        S_PS2    = 24'h000200,
        S_PS3    = 24'h000400,
        S_RSRD   = 24'h000800,
        S_RSWA   = 24'h001000,
        S_RSWB   = 24'h002000,
        S_PKRD   = 24'h004000,
        S_PKCAP  = 24'h008000,
        S_DRD    = 24'h010000,
        S_DST    = 24'h020000,
        S_DWAIT  = 24'h040000,
        S_ERD    = 24'h080000,
        S_EMUL   = 24'h100000,
        S_ESHF   = 24'h200000,
        S_EWR    = 24'h400000,
        S_DONE   = 24'h800000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] ci_reg, ci_next, cj_reg, cj_next;
    logic [CNT_W-1:0] ck_reg, ck_next;
    logic [4:0]       dim_reg;
    status_t          status_reg, status_next, done_reg, done_next;
    logic             rng_rc_reg, rng_rc_next, rng_r_reg, rng_r_next;

    logic [CNT_W-1:0] n;
    logic [6:0]       row_x, col_x, dim_x;
    logic [IDX_W-1:0] row_i, col_i, kk;
    logic             row_ok, col_ok, acc, ci_last, cj_last;

    assign dim_x  = 7'(dim_reg);
    assign n      = (dim_x == 7'd0) ? CNT_W'(1) :
                    (dim_x > 7'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(dim_x);
    assign row_x  = 7'(req.row);
    assign col_x  = 7'(req.col);
    assign row_i  = row_x[IDX_W-1:0];
    assign col_i  = col_x[IDX_W-1:0];
    assign row_ok = row_x < 7'(MAX_DIM);
    assign col_ok = col_x < 7'(MAX_DIM);
    assign kk     = ck_reg[IDX_W-1:0];
    assign ci_last = (CNT_W'(ci_reg) + CNT_W'(1)) == n;
    assign cj_last = (CNT_W'(cj_reg) + CNT_W'(1)) == n;

    assign req.ready = (state_reg == S_IDLE) && !stat.out_full;
    assign acc       = req.valid && req.ready;

    always_comb
    begin
        state_next  = state_reg;
        ci_next     = ci_reg;
        cj_next     = cj_reg;
        ck_next     = ck_reg;
        status_next = status_reg;
        done_next   = done_reg;
        rng_rc_next = rng_rc_reg;
        rng_r_next  = rng_r_reg;
        cmd         = '{op: OP_NONE, in_range: 1'b0, upper: 1'b0, diag: 1'b0,
                        pmark: 1'b0, lsw: 1'b0, status: status_reg};
        wa          = {ci_reg, cj_reg};
        wb          = {kd, cj_reg};
        la          = {ci_reg, cj_reg};
        lb          = {kd, cj_reg};
        ua          = {kk, cj_reg};
        pa          = ci_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (req.command)
                        CMD_LOAD:
                        begin
                            cmd.op       = OP_LOAD;
                            cmd.in_range = row_ok && col_ok;
                            cmd.status   = ST_PENDING;
                            wa           = {row_i, col_i};
                            status_next  = ST_PENDING;
                        end
                        CMD_START:
                        begin
                            ci_next    = '0;
                            cj_next    = '0;
                            ck_next    = '0;
                            state_next = S_INIT;
                        end
                        CMD_READ:
                        begin
                            cmd.op      = OP_RD_ENTRY;
                            la          = {row_i, col_i};
                            ua          = {row_i, col_i};
                            pa          = row_i;
                            ci_next     = row_i;
                            rng_rc_next = row_ok && col_ok;
                            rng_r_next  = row_ok;
                            state_next  = S_READ;
                        end
                        default:
                        begin
                            cmd.op = OP_RESP;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.op       = OP_RESP_RD;
                cmd.in_range = rng_rc_reg;
                cmd.upper    = rng_r_reg;
                state_next   = S_IDLE;
            end
            S_INIT:
            begin
                cmd.op       = OP_INIT;
                cmd.in_range = (CNT_W'(ci_reg) < n) && (CNT_W'(cj_reg) < n);
                cmd.upper    = cj_reg > ci_reg;
                cmd.diag     = cj_reg == ci_reg;
                cmd.pmark    = cj_reg == '0;
                if (cj_reg == IDX_LAST)
                begin
                    cj_next = '0;
                    if (ci_reg == IDX_LAST)
                    begin
                        state_next = S_KTOP;
                    end
                    else
                    begin
                        ci_next = ci_reg + 1'b1;
                    end
                end
                else
                begin
                    cj_next = cj_reg + 1'b1;
                end
            end
            S_KTOP:
            begin
                if (ck_reg == n)
                begin
                    done_next  = ST_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_PIV_CLR;
                    ci_next    = kk;
                    state_next = S_PIV;
                end
            end
            S_PIV:
            begin
                cmd.op = OP_PIV_RD;
                wa     = {ci_reg, kk};
                if (ci_last)
                begin
                    state_next = S_PIVW;
                end
                else
                begin
                    ci_next = ci_reg + 1'b1;
                end
            end
            S_PIVW:
            begin
                state_next = S_PIVCHK;
            end
            S_PIVCHK:
            begin
                if (stat.found)
                begin
                    state_next = S_PS0;
                end
                else
                begin
                    done_next  = ST_SINGULAR;
                    state_next = S_DONE;
                end
            end
            S_PS0:
            begin
                cmd.op     = OP_PRD;
                pa         = kk;
                state_next = S_PS1;
            end
            S_PS1:
            begin
                cmd.op     = OP_PSAVE_RD;
                pa         = kd;
                state_next = S_PS2;
            end
            S_PS2:
            begin
                cmd.op     = OP_PWR_NEW;
                pa         = kk;
                state_next = S_PS3;
            end
            S_PS3:
            begin
                cmd.op     = OP_PWR_OLD;
                pa         = kd;
                cj_next    = '0;
                state_next = S_RSRD;
            end
            S_RSRD:
            begin
                cmd.op     = OP_RS_RD;
                wa         = {kk, cj_reg};
                la         = {kk, cj_reg};
                state_next = S_RSWA;
            end
            S_RSWA:
            begin
                cmd.op     = OP_RS_WA;
                cmd.lsw    = CNT_W'(cj_reg) < ck_reg;
                wa         = {kk, cj_reg};
                la         = {kk, cj_reg};
                state_next = S_RSWB;
            end
            S_RSWB:
            begin
                cmd.op  = OP_RS_WB;
                cmd.lsw = CNT_W'(cj_reg) < ck_reg;
                wa      = {kd, cj_reg};
                la      = {kd, cj_reg};
                if (cj_last)
                begin
                    state_next = S_PKRD;
                end
                else
                begin
                    cj_next    = cj_reg + 1'b1;
                    state_next = S_RSRD;
                end
            end
            S_PKRD:
            begin
                cmd.op     = OP_PIVK_RD;
                wa         = {kk, kk};
                state_next = S_PKCAP;
            end
            S_PKCAP:
            begin
                cmd.op     = OP_PIVK_CAP;
                ci_next    = kk;
                state_next = S_DRD;
            end
            S_DRD:
            begin
                cmd.op     = OP_D_RD;
                wa         = {ci_reg, kk};
                wb         = {kk, ci_reg};
                state_next = S_DST;
            end
            S_DST:
            begin
                cmd.op     = OP_D_START;
                ua         = {kk, ci_reg};
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                la = {ci_reg, kk};
                if (!stat.div_busy)
                begin
                    cmd.op = OP_D_WR;
                    if (ci_last)
                    begin
                        ci_next    = kk;
                        cj_next    = kk;
                        state_next = S_ERD;
                    end
                    else
                    begin
                        ci_next    = ci_reg + 1'b1;
                        state_next = S_DRD;
                    end
                end
            end
            S_ERD:
            begin
                cmd.op     = OP_E_RD;
                wa         = {ci_reg, cj_reg};
                la         = {ci_reg, kk};
                ua         = {kk, cj_reg};
                state_next = S_EMUL;
            end
            S_EMUL:
            begin
                cmd.op     = OP_E_MUL;
                state_next = S_ESHF;
            end
            S_ESHF:
            begin
                cmd.op     = OP_E_SHF;
                state_next = S_EWR;
            end
            S_EWR:
            begin
                cmd.op = OP_E_WR;
                wa     = {ci_reg, cj_reg};
                if (cj_last)
                begin
                    cj_next = kk;
                    if (ci_last)
                    begin
                        ck_next    = ck_reg + 1'b1;
                        state_next = S_KTOP;
                    end
                    else
                    begin
                        ci_next    = ci_reg + 1'b1;
                        state_next = S_ERD;
                    end
                end
                else
                begin
                    cj_next    = cj_reg + 1'b1;
                    state_next = S_ERD;
                end
            end
            S_DONE:
            begin
                if (!stat.out_full)
                begin
                    cmd.op      = OP_RESP;
                    cmd.status  = done_reg;
                    status_next = done_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ci_reg     <= '0;
            cj_reg     <= '0;
            ck_reg     <= '0;
            dim_reg    <= DIM_RESET;
            status_reg <= ST_PENDING;
            done_reg   <= ST_OK;
            rng_rc_reg <= 1'b0;
            rng_r_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ci_reg     <= ci_next;
            cj_reg     <= cj_next;
            ck_reg     <= ck_next;
            status_reg <= status_next;
            done_reg   <= done_next;
            rng_rc_reg <= rng_rc_next;
            rng_r_reg  <= rng_r_next;
            if (cfg_wr_en)
            begin
                dim_reg <= cfg_wr_data;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.command == CMD_START) |=> state_reg == S_INIT)
        else $error("start transfer did not begin the initial sweep");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DST) |-> !stat.div_busy)
        else $error("divider started while busy");
    a_pivot_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PS0) |-> stat.found)
        else $error("row swap without a pivot");
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && $past(state_reg) == S_DONE) |-> stat.out_full)
        else $error("decomposition finished without a response");
`endif

endmodule

@@ hdl/lu_decompose_partial_pivot.sv @@
// Top level of the LU decomposition block with partial pivoting.
// Usage:
//   req carries command, row, col and value; rsp returns status, lower_value,
//   upper_value and perm_index, one response per request transfer.
//   cfg_wr_en with cfg_wr_data sets the matrix dimension; write it only while idle.
//   A load answers in the cycle after its transfer; a read goes through the memory
//   read registers and state S_READ into the response register. A request is
//   taken only when the response register is empty, so a stalled receiver holds
//   back the next request.
//   A start transfer runs an initial copy over all MAX_DIM*MAX_DIM entries, then for
//   each column k: a pivot search over rows k..n-1, a permutation swap, a row swap,
//   a division for each row k..n-1 (one quotient bit per cycle) and an update of
//   each element of the trailing block. For large n elimination dominates.
//   Reset: dimension 16, status not yet decomposed, permutation reads as identity.
module lu_decompose_partial_pivot
    import lupp_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    lupp_req_if.sink    req,
    lupp_rsp_if.source  rsp,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data
);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = 2 * IDX_W;

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [ADDR_W-1:0] wa, wb, la, lb, ua;
    logic [IDX_W-1:0]  pa, kd;

    lupp_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .wa          (wa),
        .wb          (wb),
        .la          (la),
        .lb          (lb),
        .ua          (ua),
        .pa          (pa),
        .kd          (kd),
        .stat        (stat)
    );

    lupp_dp #(.MAX_DIM(MAX_DIM)) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .wa    (wa),
        .wb    (wb),
        .la    (la),
        .lb    (lb),
        .ua    (ua),
        .pa    (pa),
        .value (req.value),
        .kd    (kd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

@@ sim/lu_decompose_partial_pivot_tb.sv @@
// Self-checking testbench for the LU decomposition block with partial pivoting.
module lu_decompose_partial_pivot_tb;
    import lupp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_MAX = 16;
    localparam int ITEM_TARGET = 1550;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] lower_value;
        logic signed [31:0] upper_value;
        logic [3:0]         perm_index;
    } entry_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [4:0]  cfg_wr_data;

    lupp_req_if req_if ();
    lupp_rsp_if rsp_if ();

    lu_decompose_partial_pivot uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if.sink),
        .rsp         (rsp_if.source),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    logic signed [31:0] work_q  [N_MAX][N_MAX];
    logic signed [31:0] lower_q [N_MAX][N_MAX];
    logic signed [31:0] upper_q [N_MAX][N_MAX];
    logic [3:0]         perm_q  [N_MAX];
    status_t            status_q;
    logic [4:0]         dim_q;

    entry_result_t expected_results[$];
    int     error_count;
    int     items_sent;
    longint cycle_count;
    bit     idle_on;
    bit     stall_on;
    int     stall_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic signed [31:0] sat_q(longint v);
        if (v > 64'sd2147483647)
            return Q_MAX;
        if (v < -64'sd2147483648)
            return Q_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] abs_q(logic signed [31:0] v);
        longint w;
        w = v;
        return sat_q(w < 0 ? -w : w);
    endfunction

    function automatic logic signed [31:0] div_q(logic signed [31:0] num,
                                                 logic signed [31:0] den);
        longint a;
        longint b;
        a = num;
        b = den;
        if (den == 0)
            return Q_ZERO;
        return sat_q((a * 65536) / b);
    endfunction

    function automatic logic signed [31:0] mul_q(logic signed [31:0] x,
                                                 logic signed [31:0] y);
        longint a;
        longint b;
        a = x;
        b = y;
        return sat_q((a * b) / 65536);
    endfunction

    function automatic status_t factor_matrix();
        int n;
        int kd;
        bit found;
        logic signed [31:0] best;
        logic signed [31:0] m;
        logic signed [31:0] piv;
        logic signed [31:0] t;
        logic [3:0] tp;
        longint diff;
        n = dim_q;
        if (n < 1)
            n = 1;
        if (n > N_MAX)
            n = N_MAX;
        for (int i = 0; i < N_MAX; i++)
        begin
            perm_q[i] = i[3:0];
            for (int j = 0; j < N_MAX; j++)
            begin
                lower_q[i][j] = Q_ZERO;
                upper_q[i][j] = Q_ZERO;
                if (i < n && j < n)
                begin
                    if (j >= i)
                        upper_q[i][j] = work_q[i][j];
                    if (j == i)
                        lower_q[i][j] = Q_ONE;
                    else if (j < i)
                        lower_q[i][j] = work_q[i][j];
                end
            end
        end
        for (int k = 0; k < n; k++)
        begin
            best = 0;
            kd = 0;
            found = 0;
            for (int i = k; i < n; i++)
            begin
                m = abs_q(work_q[i][k]);
                if (best < m)
                begin
                    best = m;
                    kd = i;
                    found = 1;
                end
            end
            if (!found)
                return ST_SINGULAR;
            tp = perm_q[k];
            perm_q[k] = perm_q[kd];
            perm_q[kd] = tp;
            for (int j = 0; j < n; j++)
            begin
                t = work_q[k][j];
                work_q[k][j] = work_q[kd][j];
                work_q[kd][j] = t;
            end
            for (int j = 0; j < k; j++)
            begin
                t = lower_q[k][j];
                lower_q[k][j] = lower_q[kd][j];
                lower_q[kd][j] = t;
            end
            piv = work_q[k][k];
            upper_q[k][k] = piv;
            for (int i = k; i < n; i++)
            begin
                lower_q[i][k] = div_q(work_q[i][k], piv);
                upper_q[k][i] = work_q[k][i];
            end
            for (int i = k; i < n; i++)
            begin
                for (int j = k; j < n; j++)
                begin
                    diff = longint'(work_q[i][j])
                           - longint'(mul_q(lower_q[i][k], upper_q[k][j]));
                    work_q[i][j] = sat_q(diff);
                end
            end
        end
        return ST_OK;
    endfunction

    function automatic entry_result_t predict_entry(cmd_t cmd, logic [3:0] row,
                                                    logic [3:0] col,
                                                    logic signed [31:0] value);
        entry_result_t r;
        r.lower_value = Q_ZERO;
        r.upper_value = Q_ZERO;
        r.perm_index = 4'd0;
        case (cmd)
            CMD_LOAD:
            begin
                work_q[row][col] = value;
                status_q = ST_PENDING;
            end
            CMD_START:
                status_q = factor_matrix();
            CMD_READ:
            begin
                r.lower_value = lower_q[row][col];
                r.upper_value = upper_q[row][col];
                r.perm_index = perm_q[row];
            end
            default:
            begin
            end
        endcase
        r.status = status_q;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %h expected %h", $realtime, field, got, want);
        error_count++;
    endtask

    task automatic send_item(cmd_t cmd, logic [3:0] row, logic [3:0] col,
                             logic signed [31:0] value);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.command = cmd;
        req_if.row = row;
        req_if.col = col;
        req_if.value = value;
        do
            @(posedge clk);
        while (!req_if.ready);
        expected_results.push_back(predict_entry(cmd, row, col, value));
        items_sent++;
        @(negedge clk);
        req_if.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_dimension(logic [4:0] d);
        wait_drained();
        cfg_wr_en = 1'b1;
        cfg_wr_data = d;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        dim_q = d;
    endtask

    function automatic logic signed [31:0] random_element();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 2)
            return Q_ZERO;
        if (pick < 4)
            return $urandom();
        return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    task automatic load_matrix(int n, bit zero_column);
        int zc;
        zc = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                send_item(CMD_LOAD, i[3:0], j[3:0],
                          (zero_column && j == zc) ? Q_ZERO : random_element());
            end
        end
    endtask

    task automatic test_full_fill_extremes();
        logic signed [31:0] pattern [4];
        pattern[0] = Q_MAX;
        pattern[1] = Q_MIN;
        pattern[2] = 32'shffff_ffff;
        pattern[3] = Q_ZERO;
        for (int i = 0; i < N_MAX; i++)
        begin
            for (int j = 0; j < N_MAX; j++)
            begin
                send_item(CMD_LOAD, i[3:0], j[3:0],
                          (i == j) ? Q_ONE : pattern[(i + j) % 4]);
            end
        end
        send_item(CMD_START, 4'd0, 4'd0, Q_ZERO);
        send_item(CMD_READ, 4'd0, 4'd0, Q_ZERO);
        send_item(CMD_READ, 4'd15, 4'd15, Q_ZERO);
        send_item(CMD_READ, 4'd15, 4'd0, Q_ZERO);
        send_item(CMD_READ, 4'd0, 4'd15, Q_ZERO);
    endtask

    task automatic test_commands();
        send_item(CMD_NOP, 4'd15, 4'd15, Q_MIN);
        send_item(CMD_START, 4'd3, 4'd7, Q_MAX);
        send_item(CMD_READ, 4'd7, 4'd3, 32'sh5a5a_a5a5);
        send_item(CMD_NOP, 4'd0, 4'd0, Q_ZERO);
        send_item(CMD_LOAD, 4'd5, 4'd10, 32'sha5a5_5a5a);
        send_item(CMD_NOP, 4'd1, 4'd1, Q_ZERO);
        send_item(CMD_READ, 4'd10, 4'd5, Q_ZERO);
    endtask

    task automatic test_singular();
        set_dimension(5'd2);
        send_item(CMD_LOAD, 4'd0, 4'd0, Q_ZERO);
        send_item(CMD_LOAD, 4'd1, 4'd0, Q_ZERO);
        send_item(CMD_LOAD, 4'd0, 4'd1, Q_ONE);
        send_item(CMD_LOAD, 4'd1, 4'd1, Q_ONE);
        send_item(CMD_START, 4'd0, 4'd0, Q_ZERO);
        send_item(CMD_READ, 4'd1, 4'd1, Q_ZERO);
        send_item(CMD_READ, 4'd1, 4'd0, Q_ZERO);
    endtask

    task automatic test_dimension_limits();
        set_dimension(5'd0);
        send_item(CMD_START, 4'd0, 4'd0, Q_ZERO);
        send_item(CMD_READ, 4'd0, 4'd0, Q_ZERO);
        set_dimension(5'd1);
        send_item(CMD_LOAD, 4'd0, 4'd0, Q_MIN);
        send_item(CMD_START, 4'd0, 4'd0, Q_ZERO);
        send_item(CMD_READ, 4'd0, 4'd0, Q_ZERO);
        set_dimension(5'd31);
        send_item(CMD_START, 4'd0, 4'd0, Q_ZERO);
        send_item(CMD_READ, 4'd14, 4'd2, Q_ZERO);
        set_dimension(5'd17);
        send_item(CMD_START, 4'd0, 4'd0, Q_ZERO);
    endtask

    task automatic test_random_sets();
        int n;
        int pick;
        int reads;
        logic [4:0] d;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent > ITEM_TARGET * 4 / 5)
            begin
                idle_on = 0;
                stall_on = 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                d = 5'($urandom_range(2, 5));
            else if (pick < 90)
                d = 5'($urandom_range(6, 10));
            else if (pick < 96)
                d = 5'($urandom_range(0, 16));
            else if (pick < 98)
                d = 5'($urandom_range(17, 31));
            else
                d = 5'd16;
            set_dimension(d);
            n = (d == 0) ? 1 : (d > N_MAX ? N_MAX : d);
            load_matrix(n, $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 4) == 0)
                send_item(CMD_LOAD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          $urandom());
            send_item(CMD_START, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      $urandom());
            if ($urandom_range(0, 7) == 0)
                send_item(CMD_START, 4'd0, 4'd0, Q_ZERO);
            reads = $urandom_range(n, 2 * n + 2);
            for (int r = 0; r < reads; r++)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    send_item(CMD_NOP, 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), $urandom());
                else if (pick == 1)
                    send_item(CMD_READ, 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), $urandom());
                else
                    send_item(CMD_READ, 4'($urandom_range(0, n - 1)),
                              4'($urandom_range(0, n - 1)), $urandom());
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            rsp_if.ready <= 1'b1;
            if (stall_on && $urandom_range(0, 9) == 0)
                stall_left <= $urandom_range(1, 16);
        end
    end

    always @(posedge clk)
    begin
        entry_result_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("lu_decompose_partial_pivot_tb: errors");
            $finish;
        end
        else if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected response", 32'(rsp_if.status), 32'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
                if (rsp_if.lower_value !== want.lower_value)
                    report_mismatch("lower_value", rsp_if.lower_value, want.lower_value);
                if (rsp_if.upper_value !== want.upper_value)
                    report_mismatch("upper_value", rsp_if.upper_value, want.upper_value);
                if (rsp_if.perm_index !== want.perm_index)
                    report_mismatch("perm_index", 32'(rsp_if.perm_index),
                                    32'(want.perm_index));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 5'd0;
        req_if.valid = 1'b0;
        req_if.command = CMD_NOP;
        req_if.row = 4'd0;
        req_if.col = 4'd0;
        req_if.value = Q_ZERO;
        rsp_if.ready = 1'b1;
        stall_left = 0;
        error_count = 0;
        items_sent = 0;
        cycle_count = 0;
        idle_on = 1;
        stall_on = 1;
        for (int i = 0; i < N_MAX; i++)
        begin
            perm_q[i] = i[3:0];
            for (int j = 0; j < N_MAX; j++)
            begin
                work_q[i][j] = Q_ZERO;
                lower_q[i][j] = Q_ZERO;
                upper_q[i][j] = Q_ZERO;
            end
        end
        status_q = ST_PENDING;
        dim_q = DIM_RESET;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_full_fill_extremes();
        test_commands();
        test_singular();
        test_dimension_limits();
        test_random_sets();
        wait_drained();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("lu_decompose_partial_pivot_tb: clean");
        else
            $display("lu_decompose_partial_pivot_tb: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/lupp_pkg.sv
hdl/lupp_if.sv
hdl/lupp_div.sv
hdl/lupp_dp.sv
hdl/lupp_ctrl.sv
hdl/lu_decompose_partial_pivot.sv
sim/lu_decompose_partial_pivot_tb.sv
